### src/pswu_pkg.sv
// shared types and constants of the particle swarm update block
package pswu_pkg;

   localparam int MAX_PARTICLES = 32;
   localparam int COORD_W       = 24;
   localparam int LEVEL_W       = 16;
   localparam int INDEX_W       = 5;
   localparam int ADDR_W        = $clog2(MAX_PARTICLES);
   localparam int FRAC_W        = 8;
   // room for the weighted sum of three products before the shift
   localparam int ACC_W         = COORD_W + 14;

   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   localparam longint COORD_MAX_INT = (longint'(1) << (COORD_W - 1)) - 1;
   localparam longint LOAD_VEL_RAW  = longint'(50) << FRAC_W;
   localparam logic signed [COORD_W-1:0] LOAD_VEL =
      (LOAD_VEL_RAW > COORD_MAX_INT) ? COORD_MAX : COORD_W'(LOAD_VEL_RAW);

   typedef struct packed {
      logic [7:0]  inertia;
      logic [9:0]  cognitive;
      logic [9:0]  social;
      logic [22:0] vel_limit;
   } cfg_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] vel_x;
      logic signed [COORD_W-1:0] vel_y;
      logic signed [COORD_W-1:0] best_x;
      logic signed [COORD_W-1:0] best_y;
      logic [LEVEL_W-1:0]        best_level;
   } rec_type;

   typedef struct packed {
      logic mul_en;
      logic sum_en;
   } vel_ctl_type;

endpackage

### src/pswu_ram.sv
// generic single-port-write, registered-read ram
module pswu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/pswu_csr.sv
// configuration registers behind the apb-style port
module pswu_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [3:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output pswu_pkg::cfg_type cfg
);

   localparam logic [1:0] REG_INERTIA   = 2'd0;
   localparam logic [1:0] REG_COGNITIVE = 2'd1;
   localparam logic [1:0] REG_SOCIAL    = 2'd2;
   localparam logic [1:0] REG_VLIMIT    = 2'd3;

   pswu_pkg::cfg_type cfg_ff;
   logic              wr_en;
   logic [1:0]        reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inertia   <= 8'd128;
         cfg_ff.cognitive <= 10'd154;
         cfg_ff.social    <= 10'd154;
         cfg_ff.vel_limit <= 23'd6656;
      end else if (wr_en) begin
         case (reg_sel)
            REG_INERTIA:   cfg_ff.inertia   <= csr_pwdata[7:0];
            REG_COGNITIVE: cfg_ff.cognitive <= csr_pwdata[9:0];
            REG_SOCIAL:    cfg_ff.social    <= csr_pwdata[9:0];
            REG_VLIMIT:    cfg_ff.vel_limit <= csr_pwdata[22:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_INERTIA:   csr_prdata = {24'd0, cfg_ff.inertia};
         REG_COGNITIVE: csr_prdata = {22'd0, cfg_ff.cognitive};
         REG_SOCIAL:    csr_prdata = {22'd0, cfg_ff.social};
         REG_VLIMIT:    csr_prdata = {9'd0, cfg_ff.vel_limit};
         default:       csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

### src/pswu_velocity.sv
// one axis of the velocity rule: product stage, then sum, floor shift and clamp
module pswu_velocity (
   input  logic                               clock,
   input  pswu_pkg::vel_ctl_type              ctl,
   input  pswu_pkg::cfg_type                  cfg,
   input  logic signed [pswu_pkg::COORD_W-1:0] vel,
   input  logic signed [pswu_pkg::COORD_W-1:0] pos,
   input  logic signed [pswu_pkg::COORD_W-1:0] best,
   input  logic signed [pswu_pkg::COORD_W-1:0] glob,
   output logic signed [pswu_pkg::COORD_W-1:0] vel_out
);

   logic signed [pswu_pkg::COORD_W:0]    d_best;
   logic signed [pswu_pkg::COORD_W:0]    d_glob;
   logic signed [8:0]                    w_s;
   logic signed [10:0]                   c_s;
   logic signed [10:0]                   s_s;
   logic signed [pswu_pkg::COORD_W+8:0]  prod_i_ff;
   logic signed [pswu_pkg::COORD_W+11:0] prod_c_ff;
   logic signed [pswu_pkg::COORD_W+11:0] prod_s_ff;
   logic signed [pswu_pkg::ACC_W-1:0]    acc;
   logic signed [pswu_pkg::ACC_W-1:0]    sh;
   logic signed [pswu_pkg::ACC_W-1:0]    vl;
   logic signed [pswu_pkg::ACC_W-1:0]    cmax;
   logic signed [pswu_pkg::ACC_W-1:0]    lim;
   logic signed [pswu_pkg::ACC_W-1:0]    clamped;
   logic signed [pswu_pkg::COORD_W-1:0]  vel_in;
   logic signed [pswu_pkg::COORD_W-1:0]  vel_ff;

   assign d_best = {best[pswu_pkg::COORD_W-1], best} - {pos[pswu_pkg::COORD_W-1], pos};
   assign d_glob = {glob[pswu_pkg::COORD_W-1], glob} - {pos[pswu_pkg::COORD_W-1], pos};
   assign w_s    = {1'b0, cfg.inertia};
   assign c_s    = {1'b0, cfg.cognitive};
   assign s_s    = {1'b0, cfg.social};

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_i_ff <= w_s * vel;
         prod_c_ff <= c_s * d_best;
         prod_s_ff <= s_s * d_glob;
      end
      if (ctl.sum_en) begin
         vel_ff <= vel_in;
      end
   end

   always_comb begin
      acc  = pswu_pkg::ACC_W'(prod_i_ff) + pswu_pkg::ACC_W'(prod_c_ff)
           + pswu_pkg::ACC_W'(prod_s_ff);
      // arithmetic shift rounds toward minus infinity
      sh   = acc >>> pswu_pkg::FRAC_W;
      vl   = pswu_pkg::ACC_W'(cfg.vel_limit);
      cmax = pswu_pkg::ACC_W'(pswu_pkg::COORD_MAX);
      lim  = (vl > cmax) ? cmax : vl;
      if (sh > lim) begin
         clamped = lim;
      end else if (sh < -lim) begin
         clamped = -lim;
      end else begin
         clamped = sh;
      end
      vel_in = pswu_pkg::COORD_W'(clamped);
   end

   assign vel_out = vel_ff;

endmodule

### src/particle_swarm_update_core.sv
// top level of the particle swarm update block
// Usage:
//   req_* carries one request: op (load or update), particle index, start
//   position for a load and measured concentration for an update. A request
//   is taken at a clock edge with req_valid high and req_stall low.
//   rsp_* returns one result per request: the particle position and the
//   global best position and level after that request, taken with
//   rsp_valid high and rsp_stall low.
//   csr_* is the apb-style register port: inertia, cognitive gain, social
//   gain and velocity limit at byte addresses 0, 4, 8 and 12.
// Flow:
//   the whole particle record sits in one 32-entry ram with a registered
//   read. A load goes straight to its finish step; an update passes
//   through the ram read, products, sum and clamp first (the move and
//   write back land with the result). One request is in work at a time,
//   so a new request is taken only after the last one has finished; the
//   next request is taken while the result waits.
// Reset clears the global best to zero and the registers to their defaults;
//   the particle table is undefined until loaded. When the receiver stalls,
//   the result holds and a finished request waits until the output frees.
module particle_swarm_update_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_op,
   input  logic [pswu_pkg::INDEX_W-1:0]       req_index,
   input  logic signed [pswu_pkg::COORD_W-1:0] req_load_x,
   input  logic signed [pswu_pkg::COORD_W-1:0] req_load_y,
   input  logic [pswu_pkg::LEVEL_W-1:0]       req_concentration,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [pswu_pkg::COORD_W-1:0] rsp_particle_x,
   output logic signed [pswu_pkg::COORD_W-1:0] rsp_particle_y,
   output logic signed [pswu_pkg::COORD_W-1:0] rsp_global_x,
   output logic signed [pswu_pkg::COORD_W-1:0] rsp_global_y,
   output logic [pswu_pkg::LEVEL_W-1:0]       rsp_global_level,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [3:0]                         csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_UPDATE = 1'b1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MUL,
      S_SUM,
      S_FIN
   } state_type;

   state_type                         state_ff;
   state_type                         state_in;
   pswu_pkg::cfg_type                 cfg;
   pswu_pkg::vel_ctl_type             vel_ctl;
   pswu_pkg::rec_type                 rd_rec;
   pswu_pkg::rec_type                 upd_rec;
   pswu_pkg::rec_type                 ld_rec;
   pswu_pkg::rec_type                 wr_rec;

   logic                              accept;
   logic                              fin;
   logic                              in_range;
   logic                              better;
   logic                              rd_en;
   logic                              wr_en;
   logic signed [pswu_pkg::COORD_W-1:0] vel_x;
   logic signed [pswu_pkg::COORD_W-1:0] vel_y;
   logic signed [pswu_pkg::COORD_W:0]   sum_x;
   logic signed [pswu_pkg::COORD_W:0]   sum_y;
   logic signed [pswu_pkg::COORD_W-1:0] new_x;
   logic signed [pswu_pkg::COORD_W-1:0] new_y;

   logic                              op_ff;
   logic [pswu_pkg::INDEX_W-1:0]      index_ff;
   logic signed [pswu_pkg::COORD_W-1:0] load_x_ff;
   logic signed [pswu_pkg::COORD_W-1:0] load_y_ff;
   logic [pswu_pkg::LEVEL_W-1:0]      conc_ff;

   logic signed [pswu_pkg::COORD_W-1:0] gbest_x_ff;
   logic signed [pswu_pkg::COORD_W-1:0] gbest_y_ff;
   logic [pswu_pkg::LEVEL_W-1:0]      glevel_ff;
   logic signed [pswu_pkg::COORD_W-1:0] gbest_x_in;
   logic signed [pswu_pkg::COORD_W-1:0] gbest_y_in;
   logic [pswu_pkg::LEVEL_W-1:0]      glevel_in;

   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic signed [pswu_pkg::COORD_W-1:0] rsp_px_ff;
   logic signed [pswu_pkg::COORD_W-1:0] rsp_py_ff;
   logic signed [pswu_pkg::COORD_W-1:0] rsp_gx_ff;
   logic signed [pswu_pkg::COORD_W-1:0] rsp_gy_ff;
   logic [pswu_pkg::LEVEL_W-1:0]      rsp_gl_ff;
   logic signed [pswu_pkg::COORD_W-1:0] rsp_px_in;
   logic signed [pswu_pkg::COORD_W-1:0] rsp_py_in;

   pswu_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign rd_en     = accept && (req_op == OP_UPDATE);

   pswu_ram #(
      .WIDTH ($bits(pswu_pkg::rec_type)),
      .DEPTH (pswu_pkg::MAX_PARTICLES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pswu_pkg::ADDR_W'(index_ff)),
      .wr_data (wr_rec),
      .rd_en   (rd_en),
      .rd_addr (pswu_pkg::ADDR_W'(req_index)),
      .rd_data (rd_rec)
   );

   assign vel_ctl.mul_en = (state_ff == S_MUL);
   assign vel_ctl.sum_en = (state_ff == S_SUM);

   pswu_velocity u_vel_x (
      .clock   (clock),
      .ctl     (vel_ctl),
      .cfg     (cfg),
      .vel     (rd_rec.vel_x),
      .pos     (rd_rec.pos_x),
      .best    (rd_rec.best_x),
      .glob    (gbest_x_ff),
      .vel_out (vel_x)
   );

   pswu_velocity u_vel_y (
      .clock   (clock),
      .ctl     (vel_ctl),
      .cfg     (cfg),
      .vel     (rd_rec.vel_y),
      .pos     (rd_rec.pos_y),
      .best    (rd_rec.best_y),
      .glob    (gbest_y_ff),
      .vel_out (vel_y)
   );

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_op;
         index_ff  <= req_index;
         load_x_ff <= req_load_x;
         load_y_ff <= req_load_y;
         conc_ff   <= req_concentration;
      end
   end

   // move, best refresh and result of the finishing request
   always_comb begin
      fin      = (state_ff == S_FIN) && (!rsp_valid_ff || !rsp_stall);
      in_range = int'(index_ff) < pswu_pkg::MAX_PARTICLES;

      sum_x = {rd_rec.pos_x[pswu_pkg::COORD_W-1], rd_rec.pos_x}
            + {vel_x[pswu_pkg::COORD_W-1], vel_x};
      sum_y = {rd_rec.pos_y[pswu_pkg::COORD_W-1], rd_rec.pos_y}
            + {vel_y[pswu_pkg::COORD_W-1], vel_y};
      if (sum_x > (pswu_pkg::COORD_W+1)'(pswu_pkg::COORD_MAX)) begin
         new_x = pswu_pkg::COORD_MAX;
      end else if (sum_x < (pswu_pkg::COORD_W+1)'(pswu_pkg::COORD_MIN)) begin
         new_x = pswu_pkg::COORD_MIN;
      end else begin
         new_x = pswu_pkg::COORD_W'(sum_x);
      end
      if (sum_y > (pswu_pkg::COORD_W+1)'(pswu_pkg::COORD_MAX)) begin
         new_y = pswu_pkg::COORD_MAX;
      end else if (sum_y < (pswu_pkg::COORD_W+1)'(pswu_pkg::COORD_MIN)) begin
         new_y = pswu_pkg::COORD_MIN;
      end else begin
         new_y = pswu_pkg::COORD_W'(sum_y);
      end

      better             = conc_ff > rd_rec.best_level;
      upd_rec.pos_x      = new_x;
      upd_rec.pos_y      = new_y;
      upd_rec.vel_x      = vel_x;
      upd_rec.vel_y      = vel_y;
      upd_rec.best_x     = better ? new_x : rd_rec.best_x;
      upd_rec.best_y     = better ? new_y : rd_rec.best_y;
      upd_rec.best_level = better ? conc_ff : rd_rec.best_level;

      ld_rec.pos_x      = load_x_ff;
      ld_rec.pos_y      = load_y_ff;
      ld_rec.vel_x      = pswu_pkg::LOAD_VEL;
      ld_rec.vel_y      = pswu_pkg::LOAD_VEL;
      ld_rec.best_x     = load_x_ff;
      ld_rec.best_y     = load_y_ff;
      ld_rec.best_level = '0;

      wr_rec = (op_ff == OP_UPDATE) ? upd_rec : ld_rec;
      wr_en  = fin && in_range;

      gbest_x_in = gbest_x_ff;
      gbest_y_in = gbest_y_ff;
      glevel_in  = glevel_ff;
      if (in_range) begin
         if (op_ff == OP_LOAD) begin
            if (index_ff == '0) begin
               gbest_x_in = load_x_ff;
               gbest_y_in = load_y_ff;
               glevel_in  = '0;
            end
         end else if (conc_ff > glevel_ff) begin
            // global best takes the refreshed personal best
            gbest_x_in = upd_rec.best_x;
            gbest_y_in = upd_rec.best_y;
            glevel_in  = conc_ff;
         end
      end

      rsp_px_in = in_range ? wr_rec.pos_x : '0;
      rsp_py_in = in_range ? wr_rec.pos_y : '0;

      if (fin) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = (req_op == OP_UPDATE) ? S_MUL : S_FIN;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_MUL:   state_in = S_SUM;
         S_SUM:   state_in = S_FIN;
         S_FIN:   state_in = fin ? S_IDLE : S_FIN;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gbest_x_ff <= '0;
         gbest_y_ff <= '0;
         glevel_ff  <= '0;
      end else if (fin) begin
         gbest_x_ff <= gbest_x_in;
         gbest_y_ff <= gbest_y_in;
         glevel_ff  <= glevel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (fin) begin
         rsp_px_ff <= rsp_px_in;
         rsp_py_ff <= rsp_py_in;
         rsp_gx_ff <= gbest_x_in;
         rsp_gy_ff <= gbest_y_in;
         rsp_gl_ff <= glevel_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_particle_x   = rsp_px_ff;
   assign rsp_particle_y   = rsp_py_ff;
   assign rsp_global_x     = rsp_gx_ff;
   assign rsp_global_y     = rsp_gy_ff;
   assign rsp_global_level = rsp_gl_ff;

endmodule

### src/pswu_checker.sv
// port-level checks for the particle swarm update block, bound to the top level
module pswu_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic signed [pswu_pkg::COORD_W-1:0] rsp_particle_x,
   input logic signed [pswu_pkg::COORD_W-1:0] rsp_particle_y,
   input logic signed [pswu_pkg::COORD_W-1:0] rsp_global_x,
   input logic signed [pswu_pkg::COORD_W-1:0] rsp_global_y,
   input logic [pswu_pkg::LEVEL_W-1:0]       rsp_global_level
);

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_particle_x)
         && $stable(rsp_particle_y) && $stable(rsp_global_x)
         && $stable(rsp_global_y) && $stable(rsp_global_level))
      else $error("stalled result changed");

   // reset leaves no result and an open request channel
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("reset did not clear the channels");

   // one request in work at a time
   a_single: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while one is in work");

   // a new result frees the request side at once
   a_result_frees: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !req_stall)
      else $error("request side still stalled after result");

endmodule

bind particle_swarm_update_core pswu_checker u_checker (.*);

### bench/swarm_bench_pkg.sv
// op codes, register map and coordinate types shared by the swarm update bench
package swarm_bench_pkg;

   typedef logic signed [pswu_pkg::COORD_W-1:0] coord_type;
   typedef logic [pswu_pkg::LEVEL_W-1:0]        level_type;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_UPDATE = 1'b1;

   // register index, byte address is index * 4
   typedef enum logic [1:0] {
      REG_INERTIA   = 2'd0,
      REG_COGNITIVE = 2'd1,
      REG_SOCIAL    = 2'd2,
      REG_VEL_LIMIT = 2'd3
   } csr_reg_type;

endpackage

### bench/swarm_update_checker.sv
// predicts each swarm update result and compares it with the block output
module swarm_update_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic                           req_op,
   input  logic [pswu_pkg::INDEX_W-1:0]   req_index,
   input  swarm_bench_pkg::coord_type     req_load_x,
   input  swarm_bench_pkg::coord_type     req_load_y,
   input  swarm_bench_pkg::level_type     req_concentration,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  swarm_bench_pkg::coord_type     rsp_particle_x,
   input  swarm_bench_pkg::coord_type     rsp_particle_y,
   input  swarm_bench_pkg::coord_type     rsp_global_x,
   input  swarm_bench_pkg::coord_type     rsp_global_y,
   input  swarm_bench_pkg::level_type     rsp_global_level,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [3:0]                     csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   input  logic                           csr_pready,
   output int                             fail_count,
   output int                             pending
);

   typedef struct packed {
      swarm_bench_pkg::coord_type particle_x;
      swarm_bench_pkg::coord_type particle_y;
      swarm_bench_pkg::coord_type global_x;
      swarm_bench_pkg::coord_type global_y;
      swarm_bench_pkg::level_type global_level;
   } swarm_report_type;

   pswu_pkg::rec_type          particles [pswu_pkg::MAX_PARTICLES];
   pswu_pkg::cfg_type          settings;
   swarm_bench_pkg::coord_type lead_x;
   swarm_bench_pkg::coord_type lead_y;
   swarm_bench_pkg::level_type lead_level;
   swarm_report_type           awaited_reports [$];

   function automatic swarm_bench_pkg::coord_type saturate_coord(longint value);
      if (value > pswu_pkg::COORD_MAX_INT) return pswu_pkg::COORD_MAX;
      if (value < -pswu_pkg::COORD_MAX_INT - 1) return pswu_pkg::COORD_MIN;
      return swarm_bench_pkg::coord_type'(value);
   endfunction

   function automatic swarm_bench_pkg::coord_type steer_velocity(
         swarm_bench_pkg::coord_type vel, swarm_bench_pkg::coord_type pos,
         swarm_bench_pkg::coord_type best, swarm_bench_pkg::coord_type lead);
      longint acc_sum;
      longint step;
      longint lim;
      acc_sum = longint'(settings.inertia) * longint'(vel)
              + longint'(settings.cognitive) * (longint'(best) - longint'(pos))
              + longint'(settings.social) * (longint'(lead) - longint'(pos));
      // arithmetic shift rounds toward minus infinity
      step = acc_sum >>> pswu_pkg::FRAC_W;
      lim = longint'(settings.vel_limit);
      if (lim > pswu_pkg::COORD_MAX_INT) lim = pswu_pkg::COORD_MAX_INT;
      if (step > lim) step = lim;
      else if (step < -lim) step = -lim;
      return swarm_bench_pkg::coord_type'(step);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      fail_count++;
   endtask

   task automatic advance_swarm();
      int unsigned       slot;
      pswu_pkg::rec_type p;
      swarm_report_type  r;
      slot = req_index;
      p = particles[slot];
      if (req_op == swarm_bench_pkg::OP_LOAD) begin
         p.pos_x      = req_load_x;
         p.pos_y      = req_load_y;
         p.vel_x      = pswu_pkg::LOAD_VEL;
         p.vel_y      = pswu_pkg::LOAD_VEL;
         p.best_x     = req_load_x;
         p.best_y     = req_load_y;
         p.best_level = '0;
         if (slot == 0) begin
            lead_x     = req_load_x;
            lead_y     = req_load_y;
            lead_level = '0;
         end
      end else begin
         // global best from before this request
         p.vel_x = steer_velocity(p.vel_x, p.pos_x, p.best_x, lead_x);
         p.vel_y = steer_velocity(p.vel_y, p.pos_y, p.best_y, lead_y);
         p.pos_x = saturate_coord(longint'(p.pos_x) + longint'(p.vel_x));
         p.pos_y = saturate_coord(longint'(p.pos_y) + longint'(p.vel_y));
         if (req_concentration > p.best_level) begin
            p.best_x     = p.pos_x;
            p.best_y     = p.pos_y;
            p.best_level = req_concentration;
         end
         if (req_concentration > lead_level) begin
            lead_x     = p.best_x;
            lead_y     = p.best_y;
            lead_level = req_concentration;
         end
      end
      particles[slot] = p;
      r.particle_x   = p.pos_x;
      r.particle_y   = p.pos_y;
      r.global_x     = lead_x;
      r.global_y     = lead_y;
      r.global_level = lead_level;
      awaited_reports = {awaited_reports, r};
   endtask

   task automatic check_report();
      swarm_report_type want;
      if (awaited_reports.size() == 0) begin
         report_mismatch($sformatf("result with no request waiting, particle_x %0d",
                                   rsp_particle_x));
         return;
      end
      want = awaited_reports.pop_front();
      if (rsp_particle_x !== want.particle_x)
         report_mismatch($sformatf("particle_x got %0d expected %0d",
                                   rsp_particle_x, want.particle_x));
      if (rsp_particle_y !== want.particle_y)
         report_mismatch($sformatf("particle_y got %0d expected %0d",
                                   rsp_particle_y, want.particle_y));
      if (rsp_global_x !== want.global_x)
         report_mismatch($sformatf("global_x got %0d expected %0d",
                                   rsp_global_x, want.global_x));
      if (rsp_global_y !== want.global_y)
         report_mismatch($sformatf("global_y got %0d expected %0d",
                                   rsp_global_y, want.global_y));
      if (rsp_global_level !== want.global_level)
         report_mismatch($sformatf("global_level got %0d expected %0d",
                                   rsp_global_level, want.global_level));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         settings.inertia   = 8'd128;
         settings.cognitive = 10'd154;
         settings.social    = 10'd154;
         settings.vel_limit = 23'd6656;
         lead_x             = '0;
         lead_y             = '0;
         lead_level         = '0;
         fail_count         = 0;
         awaited_reports.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               swarm_bench_pkg::REG_INERTIA:   settings.inertia   = csr_pwdata[7:0];
               swarm_bench_pkg::REG_COGNITIVE: settings.cognitive = csr_pwdata[9:0];
               swarm_bench_pkg::REG_SOCIAL:    settings.social    = csr_pwdata[9:0];
               swarm_bench_pkg::REG_VEL_LIMIT: settings.vel_limit = csr_pwdata[22:0];
               default: ;
            endcase
         end
         // a result never belongs to the request taken at the same edge
         if (rsp_valid && !rsp_stall) check_report();
         if (req_valid && !req_stall) advance_swarm();
      end
      pending <= awaited_reports.size();
   end

endmodule

### bench/particle_swarm_update_core_tb.sv
// stimulus and verdict for the particle swarm update core
module particle_swarm_update_core_tb;

   localparam int unsigned CYCLE_LIMIT = 500000;

   logic                         clock             = 1'b0;
   logic                         reset             = 1'b1;
   logic                         req_valid         = 1'b0;
   logic                         req_op            = swarm_bench_pkg::OP_LOAD;
   logic [pswu_pkg::INDEX_W-1:0] req_index         = '0;
   swarm_bench_pkg::coord_type   req_load_x        = '0;
   swarm_bench_pkg::coord_type   req_load_y        = '0;
   swarm_bench_pkg::level_type   req_concentration = '0;
   logic                         rsp_stall         = 1'b0;
   logic                         csr_psel          = 1'b0;
   logic                         csr_penable       = 1'b0;
   logic                         csr_pwrite        = 1'b0;
   logic [3:0]                   csr_paddr         = '0;
   logic [31:0]                  csr_pwdata        = '0;

   logic                         req_stall;
   logic                         rsp_valid;
   swarm_bench_pkg::coord_type   rsp_particle_x;
   swarm_bench_pkg::coord_type   rsp_particle_y;
   swarm_bench_pkg::coord_type   rsp_global_x;
   swarm_bench_pkg::coord_type   rsp_global_y;
   swarm_bench_pkg::level_type   rsp_global_level;
   logic [31:0]                  csr_prdata;
   logic                         csr_pready;

   int                           fail_count;
   int                           pending;
   int unsigned                  cycle_count = 0;
   int unsigned                  gap_pct     = 0;
   int unsigned                  stall_pct   = 0;
   int unsigned                  stall_left  = 0;
   swarm_bench_pkg::level_type   level_ramp  = '0;
   logic [pswu_pkg::MAX_PARTICLES-1:0] loaded = '0;

   particle_swarm_update_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_index         (req_index),
      .req_load_x        (req_load_x),
      .req_load_y        (req_load_y),
      .req_concentration (req_concentration),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_particle_x    (rsp_particle_x),
      .rsp_particle_y    (rsp_particle_y),
      .rsp_global_x      (rsp_global_x),
      .rsp_global_y      (rsp_global_y),
      .rsp_global_level  (rsp_global_level),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   swarm_update_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_index         (req_index),
      .req_load_x        (req_load_x),
      .req_load_y        (req_load_y),
      .req_concentration (req_concentration),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_particle_x    (rsp_particle_x),
      .rsp_particle_y    (rsp_particle_y),
      .rsp_global_x      (rsp_global_x),
      .rsp_global_y      (rsp_global_y),
      .rsp_global_level  (rsp_global_level),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_pready        (csr_pready),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL particle_swarm_update_core");
         $finish;
      end
   end

   // receiver back-pressure: short bursts mostly, a long one now and then
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if ($urandom_range(99) < stall_pct) begin
         rsp_stall  <= 1'b1;
         stall_left <= ($urandom_range(9) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic int unsigned pick_gap();
      if ($urandom_range(99) >= gap_pct) return 0;
      if ($urandom_range(9) == 0) return $urandom_range(8, 30);
      return $urandom_range(1, 3);
   endfunction

   function automatic swarm_bench_pkg::coord_type pick_coord();
      int unsigned r;
      r = $urandom();
      case ($urandom_range(5))
         0: return pswu_pkg::COORD_MAX;
         1: return pswu_pkg::COORD_MIN;
         2, 3: return swarm_bench_pkg::coord_type'($signed(r[13:0]));
         default: return swarm_bench_pkg::coord_type'(r[pswu_pkg::COORD_W-1:0]);
      endcase
   endfunction

   function automatic swarm_bench_pkg::level_type pick_level();
      int unsigned r;
      r = $urandom();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2, 3, 4: return r[pswu_pkg::LEVEL_W-1:0];
         default: begin
            // slowly rising readings so personal and global bests keep moving
            level_ramp = level_ramp + swarm_bench_pkg::level_type'($urandom_range(1, 300));
            return level_ramp;
         end
      endcase
   endfunction

   task automatic send_request(input logic op, input logic [pswu_pkg::INDEX_W-1:0] idx,
                               input swarm_bench_pkg::coord_type x,
                               input swarm_bench_pkg::coord_type y,
                               input swarm_bench_pkg::level_type conc);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_op            <= op;
      req_index         <= idx;
      req_load_x        <= x;
      req_load_y        <= y;
      req_concentration <= conc;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op == swarm_bench_pkg::OP_LOAD) loaded[idx] = 1'b1;
   endtask

   // drains every outstanding request, then lets the pipeline settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input swarm_bench_pkg::csr_reg_type which,
                            input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {which, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_swarm(input logic [7:0] inertia, input logic [9:0] cognitive,
                                input logic [9:0] social, input logic [22:0] limit);
      csr_write(swarm_bench_pkg::REG_INERTIA, 32'(inertia));
      csr_write(swarm_bench_pkg::REG_COGNITIVE, 32'(cognitive));
      csr_write(swarm_bench_pkg::REG_SOCIAL, 32'(social));
      csr_write(swarm_bench_pkg::REG_VEL_LIMIT, 32'(limit));
   endtask

   function automatic logic [22:0] pick_limit();
      case ($urandom_range(4))
         0: return '0;
         1: return '1;
         2: return 23'($urandom_range(1, 255));
         default: return 23'($urandom_range(0, 23'h7FFFFF));
      endcase
   endfunction

   task automatic run_directed();
      send_request(swarm_bench_pkg::OP_LOAD, 5'd0, '0, '0, '1);
      send_request(swarm_bench_pkg::OP_LOAD, 5'd31, pswu_pkg::COORD_MAX,
                   pswu_pkg::COORD_MIN, '0);
      send_request(swarm_bench_pkg::OP_LOAD, 5'd1, pswu_pkg::COORD_MIN,
                   pswu_pkg::COORD_MAX, '0);
      send_request(swarm_bench_pkg::OP_LOAD, 5'd2, -24'sd1, 24'sd1, '0);
      send_request(swarm_bench_pkg::OP_UPDATE, 5'd31, '0, '0, '0);
      send_request(swarm_bench_pkg::OP_UPDATE, 5'd31, '1, '1, '1);
      send_request(swarm_bench_pkg::OP_UPDATE, 5'd1, '0, '0, 16'h8000);
      // equal to the global level, so no new global best
      send_request(swarm_bench_pkg::OP_UPDATE, 5'd0, '0, '0, '1);
      send_request(swarm_bench_pkg::OP_UPDATE, 5'd2, '0, '0, 16'h0001);
      // reloading particle 0 restarts the global best at level zero
      send_request(swarm_bench_pkg::OP_LOAD, 5'd0, pswu_pkg::COORD_MAX,
                   pswu_pkg::COORD_MAX, '0);
      send_request(swarm_bench_pkg::OP_UPDATE, 5'd2, '0, '0, 16'h0002);
      send_request(swarm_bench_pkg::OP_UPDATE, 5'd1, '0, '0, 16'h0001);
      send_request(swarm_bench_pkg::OP_UPDATE, 5'd31, '0, '0, 16'h7FFF);
      send_request(swarm_bench_pkg::OP_LOAD, 5'd16, 24'sh555555, -24'sh555556, 16'hAAAA);
      send_request(swarm_bench_pkg::OP_UPDATE, 5'd16, -24'sh555556, 24'sh555555, 16'hAAAA);
      send_request(swarm_bench_pkg::OP_UPDATE, 5'd16, '0, '0, 16'h5555);
      send_request(swarm_bench_pkg::OP_UPDATE, 5'd0, '0, '0, 16'h0003);
   endtask

   task automatic run_swarm(input int count);
      logic [pswu_pkg::INDEX_W-1:0] idx;
      for (int n = 0; n < count; n++) begin
         if (n % 50 == 0) begin
            case ($urandom_range(2))
               0: gap_pct = 0;
               1: gap_pct = 15;
               default: gap_pct = 40;
            endcase
            case ($urandom_range(2))
               0: stall_pct = 0;
               1: stall_pct = 15;
               default: stall_pct = 40;
            endcase
         end
         if ($urandom_range(99) < 18) begin
            idx = ($urandom_range(7) == 0) ? '0
                : pswu_pkg::INDEX_W'($urandom_range(pswu_pkg::MAX_PARTICLES - 1));
            send_request(swarm_bench_pkg::OP_LOAD, idx, pick_coord(), pick_coord(),
                         pick_level());
         end else begin
            // only particles that have been placed are moved
            do idx = pswu_pkg::INDEX_W'($urandom_range(pswu_pkg::MAX_PARTICLES - 1));
            while (!loaded[idx]);
            send_request(swarm_bench_pkg::OP_UPDATE, idx, pick_coord(), pick_coord(),
                         pick_level());
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      gap_pct   = 20;
      stall_pct = 20;
      run_directed();
      run_swarm(150);

      wait_idle();
      program_swarm('1, '1, '1, '1);
      run_swarm(120);

      // zero limit pins every particle in place
      wait_idle();
      program_swarm('0, '0, '0, '0);
      run_swarm(80);

      for (int phase = 0; phase < 3; phase++) begin
         wait_idle();
         program_swarm(8'($urandom_range(255)), 10'($urandom_range(1023)),
                       10'($urandom_range(1023)), pick_limit());
         run_swarm(160);
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS particle_swarm_update_core");
      end else begin
         $display("FAIL particle_swarm_update_core");
      end
      $finish;
   end

endmodule
